[sv/ltlm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the loopback tick latency meter
// no dependencies

package ltlm_pkg;

   localparam int TIME_W   = 48;
   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 15;
   localparam int HOLD_W   = 20;
   localparam int LAT_W    = 21;
   localparam int DIFF_W   = TIME_W + 1;
   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = HOLD_W;

   localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(22938);
   localparam logic [HOLD_W-1:0] HOLDOFF_RST   = HOLD_W'(950000);

   localparam logic [CSR_AW-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_HOLDOFF   = 1'b1;

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [HOLD_W-1:0] holdoff_us;
   } ltlm_cfg_type;

   typedef struct packed {
      logic                    sent;
      logic                    meas;
      logic signed [LAT_W-1:0] lat;
   } ltlm_cmd_type;

endpackage

[sv/ltlm_front.sv]
`timescale 1ns / 1ps
// front end: takes samples, tracks send and receive tick times, classifies
// depends on ltlm_pkg

module ltlm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  ltlm_pkg::ltlm_cfg_type            cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic                              in_kind,
   input  logic [ltlm_pkg::TIME_W-1:0]       in_time,
   input  logic signed [ltlm_pkg::SAMPLE_W-1:0] in_sample,
   input  logic                              q_full,
   output logic                              q_push,
   output ltlm_pkg::ltlm_cmd_type            q_cmd
);
   import ltlm_pkg::*;

   logic                       vld_ff, vld_in;
   logic                       kind_ff;
   logic [TIME_W-1:0]          time_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [TIME_W-1:0]          send_time_ff, send_time_in;
   logic [TIME_W-1:0]          recv_time_ff, recv_time_in;

   logic [SAMPLE_W:0]          mag;
   logic                       loud;
   logic signed [DIFF_W-1:0]   diff_s, diff_r, hold_ext;
   logic                       send_blk, recv_blk;
   logic                       sent, meas;
   logic signed [LAT_W-1:0]    lat;
   logic [DIFF_W-LAT_W:0]      upper;

   always_comb begin
      mag = sample_ff[SAMPLE_W-1]
            ? (SAMPLE_W+1)'(-$signed({sample_ff[SAMPLE_W-1], sample_ff}))
            : {1'b0, sample_ff};
      loud     = mag > (SAMPLE_W+1)'(cfg.threshold);
      diff_s   = $signed({1'b0, time_ff}) - $signed({1'b0, send_time_ff});
      diff_r   = $signed({1'b0, time_ff}) - $signed({1'b0, recv_time_ff});
      hold_ext = $signed({{(DIFF_W-HOLD_W){1'b0}}, cfg.holdoff_us});
      send_blk = (send_time_ff != '0) && (diff_s <= hold_ext);
      recv_blk = (recv_time_ff != '0) && (diff_r <= hold_ext);
      sent     = (kind_ff == KIND_SEND) && !send_blk && loud;
      meas     = (kind_ff == KIND_RECV) && (send_time_ff != '0) && !recv_blk && loud;
      upper    = diff_s[DIFF_W-1:LAT_W-1];
      if (!diff_s[DIFF_W-1] && (upper != '0)) begin
         lat = {1'b0, {(LAT_W-1){1'b1}}};
      end else if (diff_s[DIFF_W-1] && (upper != '1)) begin
         lat = {1'b1, {(LAT_W-1){1'b0}}};
      end else begin
         lat = diff_s[LAT_W-1:0];
      end
   end

   assign q_push    = vld_ff && !q_full;
   assign in_ready  = !vld_ff || !q_full;
   assign q_cmd.sent = sent;
   assign q_cmd.meas = meas;
   assign q_cmd.lat  = lat;

   always_comb begin
      vld_in       = vld_ff;
      send_time_in = send_time_ff;
      recv_time_in = recv_time_ff;
      if (q_push) begin
         vld_in = 1'b0;
         if (sent) begin
            send_time_in = time_ff;
         end
         if (meas) begin
            recv_time_in = time_ff;
         end
      end
      if (in_valid && in_ready) begin
         vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         send_time_ff <= '0;
         recv_time_ff <= '0;
      end else begin
         vld_ff       <= vld_in;
         send_time_ff <= send_time_in;
         recv_time_ff <= recv_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         kind_ff   <= in_kind;
         time_ff   <= in_time;
         sample_ff <= in_sample;
      end
   end

endmodule

[sv/ltlm_queue.sv]
`timescale 1ns / 1ps
// short command queue between front end and back end
// depends on ltlm_pkg

module ltlm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ltlm_pkg::ltlm_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output logic                   valid,
   output ltlm_pkg::ltlm_cmd_type pop_cmd
);
   import ltlm_pkg::*;

   ltlm_cmd_type        mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]       cnt_ff, cnt_in;

   assign full    = cnt_ff == (Q_AW+1)'(Q_DEPTH);
   assign valid   = cnt_ff != '0;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("queue pop while empty");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (Q_AW+1)'(Q_DEPTH))
      else $error("queue count out of range");

endmodule

[sv/ltlm_back.sv]
`timescale 1ns / 1ps
// back end: latency ring, running sum and positive count, serial divider
// for the average, result register; depends on ltlm_pkg

module ltlm_back #(
   parameter int RING_DEPTH = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ltlm_pkg::ltlm_cmd_type            q_cmd,
   output logic                              q_pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic                              out_sent,
   output logic                              out_meas,
   output logic signed [ltlm_pkg::LAT_W-1:0] out_last,
   output logic signed [ltlm_pkg::LAT_W-1:0] out_avg
);
   import ltlm_pkg::*;

   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W = LAT_W + CNT_W;
   localparam int BC_W  = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_type;

   state_type                 state_ff;
   logic signed [LAT_W-1:0]   ring_ff [RING_DEPTH];
   logic [RING_DEPTH-1:0]     ring_vld_ff;
   logic [IDX_W-1:0]          wr_idx_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]          pos_cnt_ff;
   logic signed [LAT_W-1:0]   last_ff;
   logic signed [LAT_W-1:0]   avg_ff;
   logic [CNT_W-1:0]          rem_ff;
   logic [SUM_W-1:0]          quo_ff;
   logic [CNT_W-1:0]          div_ff;
   logic                      neg_ff;
   logic [BC_W-1:0]           bit_cnt_ff;
   logic                      rsp_vld_ff;
   logic                      rsp_sent_ff;
   logic                      rsp_meas_ff;
   logic signed [LAT_W-1:0]   rsp_last_ff;
   logic signed [LAT_W-1:0]   rsp_avg_ff;

   logic                      out_free;
   logic                      rsp_load;
   logic signed [LAT_W-1:0]   old_val;
   logic signed [SUM_W-1:0]   sum_in;
   logic [CNT_W-1:0]          cnt_in;
   logic [SUM_W-1:0]          abs_sum;
   logic [IDX_W-1:0]          wr_idx_in;
   logic [CNT_W:0]            trial;
   logic                      ge;
   logic signed [SUM_W:0]     quo_s;
   logic [SUM_W-LAT_W+1:0]    upper;
   logic signed [LAT_W-1:0]   avg_sat;

   assign out_free = !rsp_vld_ff || out_ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid && (q_cmd.meas || out_free);
   assign rsp_load = (q_pop && !q_cmd.meas) || ((state_ff == S_FIN) && out_free);

   always_comb begin
      old_val   = ring_vld_ff[wr_idx_ff] ? ring_ff[wr_idx_ff] : '0;
      sum_in    = sum_ff - SUM_W'(old_val) + SUM_W'(q_cmd.lat);
      cnt_in    = pos_cnt_ff - CNT_W'(old_val > 0) + CNT_W'(q_cmd.lat > 0);
      abs_sum   = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      wr_idx_in = (wr_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      ge        = trial >= {1'b0, div_ff};
      quo_s     = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      upper     = quo_s[SUM_W:LAT_W-1];
      if (!quo_s[SUM_W] && (upper != '0)) begin
         avg_sat = {1'b0, {(LAT_W-1){1'b1}}};
      end else if (quo_s[SUM_W] && (upper != '1)) begin
         avg_sat = {1'b1, {(LAT_W-1){1'b0}}};
      end else begin
         avg_sat = quo_s[LAT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ring_vld_ff <= '0;
         wr_idx_ff   <= '0;
         sum_ff      <= '0;
         pos_cnt_ff  <= '0;
         last_ff     <= '0;
         avg_ff      <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  if (q_cmd.meas) begin
                     ring_ff[wr_idx_ff]     <= q_cmd.lat;
                     ring_vld_ff[wr_idx_ff] <= 1'b1;
                     wr_idx_ff              <= wr_idx_in;
                     sum_ff                 <= sum_in;
                     pos_cnt_ff             <= cnt_in;
                     last_ff                <= q_cmd.lat;
                     rem_ff                 <= '0;
                     quo_ff                 <= abs_sum;
                     neg_ff                 <= sum_in[SUM_W-1];
                     div_ff                 <= (cnt_in == '0) ? CNT_W'(1) : cnt_in;
                     bit_cnt_ff             <= BC_W'(SUM_W);
                     state_ff               <= S_DIV;
                  end else begin
                     rsp_sent_ff <= q_cmd.sent;
                     rsp_meas_ff <= 1'b0;
                     rsp_last_ff <= last_ff;
                     rsp_avg_ff  <= avg_ff;
                  end
               end
            end
            S_DIV: begin
               rem_ff     <= ge ? CNT_W'(trial - {1'b0, div_ff}) : CNT_W'(trial);
               quo_ff     <= {quo_ff[SUM_W-2:0], ge};
               bit_cnt_ff <= bit_cnt_ff - 1'b1;
               if (bit_cnt_ff == BC_W'(1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  avg_ff      <= avg_sat;
                  rsp_sent_ff <= 1'b0;
                  rsp_meas_ff <= 1'b1;
                  rsp_last_ff <= last_ff;
                  rsp_avg_ff  <= avg_sat;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign out_valid = rsp_vld_ff;
   assign out_sent  = rsp_sent_ff;
   assign out_meas  = rsp_meas_ff;
   assign out_last  = rsp_last_ff;
   assign out_avg   = rsp_avg_ff;

   a_pos_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      pos_cnt_ff <= CNT_W'(RING_DEPTH))
      else $error("positive count exceeds ring depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= IDX_W'(RING_DEPTH - 1))
      else $error("ring write index out of range");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0) && (rem_ff < div_ff))
      else $error("divider state inconsistent");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_pop)
      else $error("queue popped while dividing");

endmodule

[sv/loopback_tick_latency_meter_unit.sv]
`timescale 1ns / 1ps
// top level of the loopback tick latency meter: control registers and wiring
// depends on ltlm_pkg, ltlm_front, ltlm_queue, ltlm_back

// The front end takes one sample per clock unless the queue is full and decides
// whether it is a send tick, a measured return tick or nothing; a two-entry
// queue passes that decision to the back end. An item that stores no latency
// is loaded into the result register when the back end pops it, so such items
// sustain one per clock while the output is ready and no divide runs. An item
// that stores a latency updates the ring sum and the positive count at once and
// then runs a one-bit-per-cycle divider for the average; no new item is popped
// until the result is loaded. The ring needs no clearing pass after reset.

module loopback_tick_latency_meter_unit #(
   parameter int RING_DEPTH = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,  // time_us, sample
   input  logic                           req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,  // last_latency_us, average_latency_us, pad
   output logic [1:0]                     rsp_tuser,  // tick_sent, measured
   input  logic                           csr_we,
   input  logic [ltlm_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [ltlm_pkg::CSR_DW-1:0]    csr_wdata
);
   import ltlm_pkg::*;

   ltlm_cfg_type            cfg_ff;
   ltlm_cmd_type            push_cmd, pop_cmd;
   logic                    q_full, q_push, q_pop, q_valid;
   logic                    out_sent, out_meas;
   logic signed [LAT_W-1:0] out_last, out_avg;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= THRESHOLD_RST;
         cfg_ff.holdoff_us <= HOLDOFF_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD: cfg_ff.threshold  <= csr_wdata[THR_W-1:0];
            CSR_HOLDOFF:   cfg_ff.holdoff_us <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   ltlm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_time   (req_tdata[TIME_W-1:0]),
      .in_sample ($signed(req_tdata[TIME_W+SAMPLE_W-1:TIME_W])),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   ltlm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   ltlm_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sent  (out_sent),
      .out_meas  (out_meas),
      .out_last  (out_last),
      .out_avg   (out_avg)
   );

   assign rsp_tdata = {(48 - 2 * LAT_W)'(0), out_avg, out_last};
   assign rsp_tuser = {out_meas, out_sent};

endmodule
